// ===== rtl/core/jic_pkg.sv =====
// ----------------------------------------------------------------------------
// jic_pkg
// Shared types, codes and marker helpers for the JPEG image carver.
// ----------------------------------------------------------------------------
package jic_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int OUT_BITS        = 32;

    // segment kinds
    localparam logic [1:0] KIND_GAP      = 2'd0;
    localparam logic [1:0] KIND_IMAGE    = 2'd1;
    localparam logic [1:0] KIND_TRAILING = 2'd2;

    // parser phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_MARK  = 3'd1;
    localparam logic [2:0] PH_LENHI = 3'd2;
    localparam logic [2:0] PH_LENLO = 3'd3;
    localparam logic [2:0] PH_SKIP  = 3'd4;

    // marker bytes
    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] MARK_STUFF  = 8'h00;
    localparam logic [7:0] MARK_TEM    = 8'h01;
    localparam logic [7:0] MARK_RST0   = 8'hD0;
    localparam logic [7:0] MARK_SOI    = 8'hD8;
    localparam logic [7:0] MARK_EOI    = 8'hD9;

    localparam logic [15:0] LEN_MIN = 16'd2;

    typedef struct packed {
        logic [1:0]          kind;
        logic [OUT_BITS-1:0] start_off;
        logic [OUT_BITS-1:0] end_off;
        logic [OUT_BITS-1:0] number;
        logic                last;
    } result_t;

    // true when the marker id is followed by a 16-bit length
    function automatic logic has_length(input logic [7:0] id);
        logic standalone;
        standalone = (id == MARK_STUFF) || (id == MARK_PREFIX) || (id == MARK_TEM)
                   || ((id >= MARK_RST0) && (id <= MARK_EOI));
        return !standalone;
    endfunction

endpackage

// ===== rtl/core/jpeg_image_carver.sv =====
// A result is queued as its byte is taken and is shown once those ahead are read.
// Throughput: one byte per cycle while byte_stall is low; a byte may give two
// results, drained at one per cycle from a four-entry queue while result_stall
// is low, so byte_stall rises only when the queue holds more than two results.
// Reset: rst_n (async, active low) clears the parser state and empties the queue;
// a byte flagged final_byte also returns the parser to its reset state.
// ----------------------------------------------------------------------------
// jpeg_image_carver
// Splits a byte stream into JPEG images (SOI..EOI) and the data around them,
// reporting each segment's kind, offsets and image count.
// ----------------------------------------------------------------------------
module jpeg_image_carver
    import jic_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,

    // byte request channel
    input  logic                byte_valid,
    output logic                byte_stall,
    input  logic [7:0]          data_byte,
    input  logic                final_byte,

    // result request channel
    output logic                result_valid,
    input  logic                result_stall,
    output logic [1:0]          segment_kind,
    output logic [OUT_BITS-1:0] start_offset,
    output logic [OUT_BITS-1:0] end_offset,
    output logic [OUT_BITS-1:0] image_number,
    output logic                last_result
);

    logic       take;
    logic       room;
    logic [1:0] res_count;
    result_t    res0, res1;
    result_t    head;

    // stall depends only on queue fill, never on byte_valid
    assign byte_stall = !room;
    assign take       = byte_valid && room;

    // Parser: state registers plus one step of marker decode per byte.
    // Emits up to two results: the gap/image result of a marker, then the
    // trailing-data result when the stream ends.
    jic_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .res_count  (res_count),
        .res0       (res0),
        .res1       (res1)
    );

    // Result queue parts the two sides: bytes keep flowing while a result
    // waits on result_stall, as long as the queue has room.
    jic_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_count (res_count),
        .wr0      (res0),
        .wr1      (res1),
        .room     (room),
        .rd_valid (result_valid),
        .rd_stall (result_stall),
        .rd_data  (head)
    );

    assign segment_kind = head.kind;
    assign start_offset = head.start_off;
    assign end_offset   = head.end_off;
    assign image_number = head.number;
    assign last_result  = head.last;

endmodule

// ===== rtl/core/jic_parser.sv =====
// ----------------------------------------------------------------------------
// jic_parser
// Marker scanner: one byte per accepted request, up to two results out.
// ----------------------------------------------------------------------------
module jic_parser
    import jic_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  logic [7:0]    data_byte,
    input  logic          final_byte,
    output logic [1:0]    res_count,
    output result_t       res0,
    output result_t       res1
);

    localparam logic [OFFSET_BITS-1:0] OFF_ONE = OFFSET_BITS'(1);

    logic                   seeking_end_reg, seeking_end_next;
    logic [2:0]             phase_reg, phase_next;
    logic [7:0]             len_hi_reg, len_hi_next;
    logic [15:0]            skip_reg, skip_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] begin_reg, begin_next;
    logic [OFFSET_BITS-1:0] prev_end_reg, prev_end_next;
    logic [OUT_BITS-1:0]    images_reg, images_next;

    logic [OFFSET_BITS-1:0] nxt;
    logic [OFFSET_BITS-1:0] soi_at;
    logic [15:0]            seg_len;
    logic [15:0]            skip_dec;
    logic                   mark_hit;
    logic                   image_now;
    logic [1:0]             mark_kind;
    logic [OFFSET_BITS-1:0] mark_start, mark_end;
    logic [OFFSET_BITS-1:0] trail_start;

    // low 32 bits of an offset, zero-extended when offsets are narrower
    function automatic logic [OUT_BITS-1:0] to_out(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+OUT_BITS-1:0] ext;
        ext = {{OUT_BITS{1'b0}}, v};
        return ext[OUT_BITS-1:0];
    endfunction

    always_comb
    begin
        nxt      = pos_reg + OFF_ONE;
        soi_at   = pos_reg - OFF_ONE;
        seg_len  = {len_hi_reg, data_byte};
        skip_dec = (skip_reg != 16'd0) ? skip_reg - 16'd1 : skip_reg;

        seeking_end_next = seeking_end_reg;
        phase_next       = phase_reg;
        len_hi_next      = len_hi_reg;
        skip_next        = skip_reg;
        begin_next       = begin_reg;
        prev_end_next    = prev_end_reg;
        images_next      = images_reg;
        mark_hit         = 1'b0;
        image_now        = 1'b0;
        mark_kind        = KIND_GAP;
        mark_start       = prev_end_reg;
        mark_end         = soi_at;

        unique case (phase_reg)
            PH_MARK:
            begin
                if ((data_byte == MARK_STUFF) || (data_byte == MARK_PREFIX))
                begin
                    phase_next = PH_IDLE;
                end
                else if (!seeking_end_reg && (data_byte == MARK_SOI))
                begin
                    mark_hit         = (soi_at != prev_end_reg);
                    prev_end_next    = soi_at;
                    begin_next       = soi_at;
                    seeking_end_next = 1'b1;
                    phase_next       = PH_IDLE;
                end
                else if (seeking_end_reg && (data_byte == MARK_EOI))
                begin
                    images_next      = images_reg + OUT_BITS'(1);
                    mark_hit         = 1'b1;
                    image_now        = 1'b1;
                    mark_kind        = KIND_IMAGE;
                    mark_start       = begin_reg;
                    mark_end         = nxt;
                    prev_end_next    = nxt;
                    seeking_end_next = 1'b0;
                    phase_next       = PH_IDLE;
                end
                else if (has_length(data_byte))
                begin
                    phase_next = PH_LENHI;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_LENHI:
            begin
                len_hi_next = data_byte;
                phase_next  = PH_LENLO;
            end
            PH_LENLO:
            begin
                if (seg_len <= LEN_MIN)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    skip_next  = seg_len - LEN_MIN;
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = (data_byte == MARK_PREFIX) ? PH_MARK : PH_IDLE;
            end
        endcase

        pos_next    = nxt;
        trail_start = seeking_end_next ? begin_next : prev_end_next;

        // results in model order: marker result first, trailing data second
        res0.kind      = mark_kind;
        res0.start_off = to_out(mark_start);
        res0.end_off   = to_out(mark_end);
        res0.number    = images_next;
        res0.last      = 1'b0;
        res1.kind      = KIND_TRAILING;
        res1.start_off = to_out(trail_start);
        res1.end_off   = to_out(nxt);
        res1.number    = images_next;
        res1.last      = 1'b1;
        res_count      = 2'd0;

        if (!take)
        begin
            res_count = 2'd0;
        end
        else if (final_byte && !image_now)
        begin
            if (mark_hit)
            begin
                res_count = 2'd2;
            end
            else
            begin
                res_count = 2'd1;
                res0      = res1;
            end
        end
        else
        begin
            res_count = {1'b0, mark_hit};
            res0.last = final_byte;
        end

        // end of stream: back to the reset state
        if (final_byte)
        begin
            seeking_end_next = 1'b0;
            phase_next       = PH_IDLE;
            len_hi_next      = 8'd0;
            skip_next        = 16'd0;
            pos_next         = '0;
            begin_next       = '0;
            prev_end_next    = '0;
            images_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeking_end_reg <= 1'b0;
            phase_reg       <= PH_IDLE;
            len_hi_reg      <= 8'd0;
            skip_reg        <= 16'd0;
            pos_reg         <= '0;
            begin_reg       <= '0;
            prev_end_reg    <= '0;
            images_reg      <= '0;
        end
        else if (take)
        begin
            seeking_end_reg <= seeking_end_next;
            phase_reg       <= phase_next;
            len_hi_reg      <= len_hi_next;
            skip_reg        <= skip_next;
            pos_reg         <= pos_next;
            begin_reg       <= begin_next;
            prev_end_reg    <= prev_end_next;
            images_reg      <= images_next;
        end
    end

endmodule

// ===== rtl/core/jic_out_fifo.sv =====
// ----------------------------------------------------------------------------
// jic_out_fifo
// Four-entry result queue: two writes, one read per cycle while rd_stall is low.
// ----------------------------------------------------------------------------
module jic_out_fifo
    import jic_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] wr_count,
    input  result_t    wr0,
    input  result_t    wr1,
    output logic       room,
    output logic       rd_valid,
    input  logic       rd_stall,
    output result_t    rd_data
);

    localparam int DEPTH = 4;

    result_t    mem [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;
    logic [1:0] wr_ptr_b;

    assign pop      = rd_valid && !rd_stall;
    assign rd_valid = (count_reg != 3'd0);
    assign rd_data  = mem[rd_ptr_reg];
    // need two free slots to take a byte
    assign room     = (count_reg <= 3'(DEPTH - 2));
    assign wr_ptr_b = wr_ptr_reg + 2'd1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + wr_count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, wr_count} - {2'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (wr_count != 2'd0)
        begin
            mem[wr_ptr_reg] <= wr0;
        end
        if (wr_count == 2'd2)
        begin
            mem[wr_ptr_b] <= wr1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== verif/tb_jpeg_image_carver.sv =====
// ----------------------------------------------------------------------------
// tb_jpeg_image_carver
// Self-checking bench for the JPEG image carver: byte streams in, segment
// reports out, each report checked against an in-bench carving predictor.
// ----------------------------------------------------------------------------
module tb_jpeg_image_carver;
    import jic_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one byte request as queued for the driver
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } byte_req_t;

    logic                clk;
    logic                rst_n;
    logic                byte_valid;
    logic                byte_stall;
    logic [7:0]          data_byte;
    logic                final_byte;
    logic                result_valid;
    logic                result_stall;
    logic [1:0]          segment_kind;
    logic [OUT_BITS-1:0] start_offset;
    logic [OUT_BITS-1:0] end_offset;
    logic [OUT_BITS-1:0] image_number;
    logic                last_result;

    byte_req_t  byte_req_q[$];     // byte requests still to be offered
    result_t    segments_due[$];   // predicted segment reports, oldest first
    logic [7:0] stream_buf[$];     // scratch for building one stream

    byte_req_t  cur_req;
    bit         byte_taken;        // byte request accepted at the last rising edge
    int         send_gap;
    int         send_calm;
    int         stall_run;
    int         recv_calm;
    bit         hold_off;          // long receiver hold-off, set by its own process
    int         errors;
    int         random_bytes;
    int         stream_len;

    // carving predictor state
    logic        hunt_eoi;         // 1 while inside an image, looking for EOI
    logic [2:0]  scan_phase;
    logic [7:0]  len_msb;
    logic [15:0] skip_cnt;
    logic [31:0] cur_pos;
    logic [31:0] img_start;
    logic [31:0] gap_start;        // end of the last reported segment
    logic [31:0] img_count;

    jpeg_image_carver uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .final_byte   (final_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .segment_kind (segment_kind),
        .start_offset (start_offset),
        .end_offset   (end_offset),
        .image_number (image_number),
        .last_result  (last_result)
    );

    // ------------------------------------------------------------------
    // Carving predictor
    // ------------------------------------------------------------------

    // marker ids followed by a 16-bit big-endian length
    function automatic logic takes_length(input logic [7:0] id);
        case (id)
            MARK_STUFF, MARK_PREFIX, MARK_TEM: takes_length = 1'b0;
            default: takes_length = (id < MARK_RST0) || (id > MARK_EOI);
        endcase
    endfunction

    task automatic clear_carver();
        hunt_eoi   = 1'b0;
        scan_phase = PH_IDLE;
        len_msb    = 8'd0;
        skip_cnt   = 16'd0;
        cur_pos    = 32'd0;
        img_start  = 32'd0;
        gap_start  = 32'd0;
        img_count  = 32'd0;
    endtask

    task automatic note_segment(input logic [1:0] kind, input logic [31:0] s,
                                input logic [31:0] e, input logic [31:0] num,
                                input logic last);
        result_t r;
        r.kind       = kind;
        r.start_off  = s;
        r.end_off    = e;
        r.number     = num;
        r.last       = last;
        segments_due = {segments_due, r};
    endtask

    // advance the carver by one byte and queue whatever segments it closes
    task automatic carve_byte(input logic [7:0] b, input logic fin);
        logic [31:0] nxt;
        logic [31:0] ff_pos;
        logic [15:0] seg_len;
        logic        image_now;
        nxt       = cur_pos + 32'd1;
        image_now = 1'b0;
        case (scan_phase)
            PH_MARK:
            begin
                if (b == MARK_STUFF || b == MARK_PREFIX)
                begin
                    scan_phase = PH_IDLE;
                end
                else if (!hunt_eoi && b == MARK_SOI)
                begin
                    // image opens at the FF; report any data since the last segment
                    ff_pos = cur_pos - 32'd1;
                    if (ff_pos != gap_start)
                        note_segment(KIND_GAP, gap_start, ff_pos, img_count, 1'b0);
                    gap_start  = ff_pos;
                    img_start  = ff_pos;
                    hunt_eoi   = 1'b1;
                    scan_phase = PH_IDLE;
                end
                else if (hunt_eoi && b == MARK_EOI)
                begin
                    img_count = img_count + 32'd1;
                    note_segment(KIND_IMAGE, img_start, nxt, img_count, fin);
                    gap_start  = nxt;
                    hunt_eoi   = 1'b0;
                    image_now  = 1'b1;
                    scan_phase = PH_IDLE;
                end
                else if (takes_length(b))
                begin
                    scan_phase = PH_LENHI;
                end
                else
                begin
                    scan_phase = PH_IDLE;
                end
            end
            PH_LENHI:
            begin
                len_msb    = b;
                scan_phase = PH_LENLO;
            end
            PH_LENLO:
            begin
                seg_len = {len_msb, b};
                if (seg_len <= LEN_MIN)
                begin
                    scan_phase = PH_IDLE;
                end
                else
                begin
                    skip_cnt   = seg_len - LEN_MIN;
                    scan_phase = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                if (skip_cnt != 16'd0)
                    skip_cnt = skip_cnt - 16'd1;
                if (skip_cnt == 16'd0)
                    scan_phase = PH_IDLE;
            end
            default: scan_phase = (b == MARK_PREFIX) ? PH_MARK : PH_IDLE;
        endcase
        cur_pos = nxt;
        if (fin)
        begin
            if (!image_now)
                note_segment(KIND_TRAILING, hunt_eoi ? img_start : gap_start, nxt,
                             img_count, 1'b1);
            clear_carver();
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // mostly no idling, some short gaps, a few long ones, plus calm stretches
    function automatic int pick_idle(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm = $urandom_range(30, 100);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_len_marker();
        logic [7:0] id;
        do
            id = 8'($urandom_range(2, 254));
        while (!takes_length(id));
        return id;
    endfunction

    // byte following an FF inside entropy-coded data
    function automatic logic [7:0] pick_after_ff();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return MARK_STUFF;
        if (r < 7) return 8'(MARK_RST0 + $urandom_range(0, 7));
        if (r < 8) return MARK_TEM;
        return MARK_PREFIX;
    endfunction

    // queue the first cut bytes of stream_buf, the last one flagged final
    task automatic queue_stream(input int cut);
        byte_req_t r;
        for (int k = 0; k < cut; k++)
        begin
            r.data     = stream_buf[k];
            r.fin      = (k == cut - 1);
            byte_req_q = {byte_req_q, r};
        end
    endtask

    // one random stream: mostly well-formed images with random content,
    // some pure FF-heavy noise, some cut short anywhere
    task automatic build_stream(output int count);
        int         seg_len;
        int         cut;
        logic [7:0] b;
        stream_buf = {};
        if ($urandom_range(0, 99) < 18)
        begin
            repeat ($urandom_range(1, 30))
            begin
                b = ($urandom_range(0, 2) == 0) ? MARK_PREFIX : 8'($urandom_range(0, 255));
                stream_buf = {stream_buf, b};
            end
        end
        else
        begin
            repeat ($urandom_range(0, 4))
                stream_buf = {stream_buf, 8'($urandom_range(0, 254))};
            repeat ($urandom_range(1, 2))
            begin
                stream_buf = {stream_buf, MARK_PREFIX, MARK_SOI};
                repeat ($urandom_range(0, 3))
                begin
                    stream_buf = {stream_buf, MARK_PREFIX, pick_len_marker()};
                    if ($urandom_range(0, 19) == 0)
                        seg_len = $urandom_range(256, 300);
                    else
                        seg_len = $urandom_range(0, 12);
                    stream_buf = {stream_buf, 8'(seg_len >> 8), 8'(seg_len)};
                    repeat ((seg_len > 2) ? seg_len - 2 : 0)
                        stream_buf = {stream_buf, 8'($urandom_range(0, 255))};
                end
                repeat ($urandom_range(0, 12))
                begin
                    b = 8'($urandom_range(0, 255));
                    stream_buf = {stream_buf, b};
                    if (b == MARK_PREFIX)
                        stream_buf = {stream_buf, pick_after_ff()};
                end
                if ($urandom_range(0, 9) != 0)
                    stream_buf = {stream_buf, MARK_PREFIX, MARK_EOI};
                repeat ($urandom_range(0, 3))
                    stream_buf = {stream_buf, 8'($urandom_range(0, 254))};
            end
        end
        cut = stream_buf.size();
        if ($urandom_range(0, 3) == 0)
            cut = $urandom_range(1, stream_buf.size());
        queue_stream(cut);
        count = cut;
    endtask

    // field compare with a report on mismatch
    function automatic bit field_ok(input string what, input logic [31:0] want,
                                    input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Monitor: checks reports on the result channel, then feeds the
    // accepted byte request into the predictor. Everything is sampled
    // at the rising edge; inputs only move on the falling edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        bit      ok;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (segments_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d/%0b",
                             $time, segment_kind, start_offset, end_offset, image_number,
                             last_result);
                    errors++;
                end
                else
                begin
                    want = segments_due.pop_front();
                    ok = 1'b1;
                    ok &= field_ok("segment_kind", 32'(want.kind), 32'(segment_kind));
                    ok &= field_ok("start_offset", want.start_off, start_offset);
                    ok &= field_ok("end_offset", want.end_off, end_offset);
                    ok &= field_ok("image_number", want.number, image_number);
                    ok &= field_ok("last_result", 32'(want.last), 32'(last_result));
                    if (!ok)
                        errors++;
                end
            end
            byte_taken = byte_valid && !byte_stall;
            if (byte_taken)
                carve_byte(data_byte, final_byte);
        end
        else
        begin
            byte_taken = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Driver: offers byte requests on the falling edge. A request stays
    // put while stalled; after acceptance either the next one follows at
    // once or valid drops for a random gap.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!byte_valid || byte_taken)
            begin
                if (send_gap > 0)
                begin
                    byte_valid <= 1'b0;
                    send_gap--;
                end
                else if (byte_req_q.size() > 0)
                begin
                    cur_req     = byte_req_q.pop_front();
                    byte_valid <= 1'b1;
                    data_byte  <= cur_req.data;
                    final_byte <= cur_req.fin;
                    send_gap    = pick_idle(send_calm);
                end
                else
                begin
                    byte_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall runs, overridden by the long hold-off.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_off)
        begin
            result_stall <= 1'b1;
        end
        else if (stall_run > 0)
        begin
            result_stall <= 1'b1;
            stall_run--;
        end
        else
        begin
            result_stall <= 1'b0;
            stall_run     = pick_idle(recv_calm);
        end
    end

    // Long hold-offs while the sender keeps going, so the result queue
    // fills and byte_stall has to rise.
    initial
    begin
        hold_off = 1'b0;
        @(posedge rst_n);
        repeat (2)
        begin
            repeat ($urandom_range(300, 1500)) @(posedge clk);
            hold_off = 1'b1;
            repeat (80) @(posedge clk);
            hold_off = 1'b0;
        end
    end

    // Watchdog: well beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("jpeg_image_carver verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        byte_valid   = 1'b0;
        data_byte    = 8'd0;
        final_byte   = 1'b0;
        result_stall = 1'b0;
        byte_taken   = 1'b0;
        send_gap     = 0;
        send_calm    = 0;
        stall_run    = 0;
        recv_calm    = 0;
        errors       = 0;
        random_bytes = 0;
        clear_carver();

        // Image at offset 0 closed by the final byte: a second SOI inside
        // the image is passed over, then a 3-byte length segment is skipped.
        stream_buf = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_SOI,
                       MARK_PREFIX, 8'hC4, 8'h00, 8'h03, 8'hAA,
                       MARK_PREFIX, MARK_EOI};
        queue_stream(stream_buf.size());

        // Leading data, an EOI while looking for SOI, stuffed FF00, then an
        // image with standalone markers and an FFFF pair, ended on a lone FF.
        stream_buf = '{MARK_STUFF, MARK_PREFIX, MARK_EOI, MARK_PREFIX, MARK_STUFF,
                       MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_RST0,
                       MARK_PREFIX, MARK_TEM, MARK_PREFIX, MARK_PREFIX,
                       MARK_PREFIX};
        queue_stream(stream_buf.size());

        // No image at all; the stream stops inside a length field.
        stream_buf = '{8'h7F, MARK_PREFIX, 8'hE0, 8'h00};
        queue_stream(stream_buf.size());

        // Short length of exactly two, then a short length of zero.
        stream_buf = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, 8'hFE, 8'h00, 8'h02,
                       MARK_PREFIX, 8'hC0, 8'h00, 8'h00, MARK_PREFIX, MARK_EOI,
                       8'h55};
        queue_stream(stream_buf.size());

        while (random_bytes < 1900)
        begin
            build_stream(stream_len);
            random_bytes += stream_len;
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (byte_req_q.size() != 0 || byte_valid)
            @(negedge clk);
        while (segments_due.size() != 0)
            @(negedge clk);
        // catch any stray report after the last expected one
        repeat (10) @(negedge clk);

        if (errors == 0 && segments_due.size() == 0)
            $display("jpeg_image_carver verification clean");
        else
            $display("jpeg_image_carver verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/jic_pkg.sv
rtl/core/jic_parser.sv
rtl/core/jic_out_fifo.sv
rtl/core/jpeg_image_carver.sv
verif/tb_jpeg_image_carver.sv
